// ----- design/swtg_pkg.sv -----
// Shared types and constants for the square-wave tone, song and sweep generator.
package swtg_pkg;

	localparam int NOTE_DEPTH_DEF = 64;

	localparam int MS_PER_MIN = 60000;
	localparam int BEAT_DIV   = 8;
	// Beat unit in ms is MS_PER_MIN / (tempo * BEAT_DIV) = (MS_PER_MIN / BEAT_DIV) / tempo.
	localparam logic [15:0] BEAT_BASE_MS = 16'(MS_PER_MIN / BEAT_DIV);

	localparam logic [15:0] STEP_MS_RST = 16'd1;
	localparam logic [7:0]  TEMPO_RST   = 8'd120;

	typedef enum logic [1:0] {
		ACT_PWM,
		ACT_TICK,
		ACT_START,
		ACT_NOTE
	} action_t;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_TONE,
		MODE_SONG,
		MODE_SWEEP
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_START_FREQ,
		REG_LEVEL,
		REG_DURATION,
		REG_STEP,
		REG_SWEEP_UP,
		REG_TEMPO
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SONG_BEAT,
		ST_SONG_NEXT,
		ST_PLAY,
		ST_DIV,
		ST_DIV_END,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_CUR,
		RD_NEXT,
		RD_ZERO
	} rd_sel_t;

	typedef struct packed {
		logic [15:0] beats;
		logic [7:0]  lvl;
		logic [15:0] freq;
	} note_entry_t;

	typedef struct packed {
		logic    mem_we;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    div_load;
		logic    out_load;
	} ctrl_t;

endpackage

// ----- design/square_wave_tone_song_sweep_generator.sv -----
// Square-wave tone generator with note-table song sequencer and frequency sweep.
//
//  channel   dir  handshake                 payload
//  ------    ---  ------------------------  -----------------------------------------
//  s_*       in   s_tvalid / s_tready       tuser: action; tdata: addr, freq, lvl, beats
//  m_*       out  m_tvalid / m_tready       tdata: duty, sounding, note_now
//  apb       in   psel & penable & pwrite   7 registers at byte address 4*i
//
//  Each item passes through accept, execute and deliver; a song tick that ends a note
//  also runs the beat, next-note (skipped on a table wrap) and play states. A start in
//  song or sweep mode runs the shared 16-step restoring divider.
//  Reset clears all control and timer state; the note table is not cleared.
//  A new item is taken while the last result still waits; delivery stalls only
//  when a second result is ready before the first has been taken.
module square_wave_tone_song_sweep_generator #(
	parameter int NOTE_DEPTH = swtg_pkg::NOTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // note_addr[5:0], note_freq[21:6], note_level[29:22],
	                              // note_beats[45:30], zero fill
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // duty[7:0], sounding[8], note_now[14:9], zero fill
);

	localparam int IW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
	localparam int AW = (IW > 6) ? IW : 6;

	// configuration registers
	swtg_pkg::mode_t mode_q;
	logic [15:0]     start_freq_q;
	logic [7:0]      level_q;
	logic [15:0]     duration_q;
	logic [15:0]     step_q;
	logic            sweep_up_q;
	logic [7:0]      tempo_q;

	// latched input beat
	swtg_pkg::action_t act_q;
	logic [5:0]        naddr_q;
	logic [15:0]       nfreq_q;
	logic [7:0]        nlvl_q;
	logic [15:0]       nbeats_q;

	// core state
	swtg_pkg::state_t state_q, state_nx;
	swtg_pkg::ctrl_t  ctrl;
	logic [15:0]      pwm_count_q;
	logic [15:0]      half_period_q;
	logic [7:0]       cur_level_q;
	logic [7:0]       duty_q;
	logic             toggle_q;
	logic             timer_run_q;
	logic [15:0]      ms_count_q;
	logic [15:0]      timer_period_q;
	logic [15:0]      beat_count_q;
	logic [IW-1:0]    note_index_q;
	logic [15:0]      sweep_index_q;
	logic [15:0]      sweep_steps_q;
	swtg_pkg::mode_t  active_mode_q;
	logic             div_song_q;

	// shared divider
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] den_q;
	logic [3:0]  div_cnt_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_diff;
	logic        div_ge;

	// note memory
	swtg_pkg::note_entry_t mem [NOTE_DEPTH];
	swtg_pkg::note_entry_t rd_q;
	swtg_pkg::note_entry_t wr_data;
	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         wr_addr;
	logic [AW-1:0]         naddr_w;
	logic [AW-1:0]         idx_w;
	logic                  addr_ok;

	// output register
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	// helpers
	logic        cfg_we;
	logic [15:0] pwm_inc;
	logic [15:0] ms_inc;
	logic [15:0] beat_inc;
	logic [15:0] sw_inc;
	logic [15:0] sw_freq;
	logic [15:0] stp;
	logic [15:0] tempo16;
	logic [IW:0] idx_inc;
	logic        idx_wrap;
	logic        tick_fire;
	logic        beat_end;

	assign pready   = 1'b1;
	assign cfg_we   = psel & penable & pwrite;
	assign s_tready = (state_q == swtg_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign pwm_inc   = pwm_count_q + 16'd1;
	assign ms_inc    = ms_count_q + 16'd1;
	assign beat_inc  = beat_count_q + 16'd1;
	assign sw_inc    = sweep_index_q + 16'd1;
	assign sw_freq   = sweep_up_q ? (start_freq_q + sw_inc) : (start_freq_q - sw_inc);
	assign stp       = (step_q == 16'd0) ? 16'd1 : step_q;
	assign tempo16   = {8'd0, (tempo_q == 8'd0) ? 8'd1 : tempo_q};
	assign idx_inc   = {1'b0, note_index_q} + (IW+1)'(1);
	assign idx_wrap  = (idx_inc == (IW+1)'(NOTE_DEPTH));
	assign tick_fire = timer_run_q && (ms_inc >= timer_period_q);
	assign beat_end  = (beat_inc >= rd_q.beats);

	assign naddr_w = AW'(naddr_q);
	assign wr_addr = naddr_w[IW-1:0];
	assign addr_ok = ((AW+1)'(naddr_q) < (AW+1)'(NOTE_DEPTH));
	assign idx_w   = AW'(note_index_q);
	assign wr_data = '{beats: nbeats_q, lvl: nlvl_q, freq: nfreq_q};

	assign rem_sh   = {rem_q, quo_q[15]};
	assign div_ge   = (rem_sh >= {1'b0, den_q});
	assign rem_diff = rem_sh - {1'b0, den_q};

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= swtg_pkg::MODE_OFF;
			start_freq_q <= '0;
			level_q      <= '0;
			duration_q   <= '0;
			step_q       <= swtg_pkg::STEP_MS_RST;
			sweep_up_q   <= 1'b0;
			tempo_q      <= swtg_pkg::TEMPO_RST;
		end else if (cfg_we) begin
			unique case (swtg_pkg::reg_idx_t'(paddr[4:2]))
				swtg_pkg::REG_MODE:       mode_q       <= swtg_pkg::mode_t'(pwdata[1:0]);
				swtg_pkg::REG_START_FREQ: start_freq_q <= pwdata[15:0];
				swtg_pkg::REG_LEVEL:      level_q      <= pwdata[7:0];
				swtg_pkg::REG_DURATION:   duration_q   <= pwdata[15:0];
				swtg_pkg::REG_STEP:       step_q       <= pwdata[15:0];
				swtg_pkg::REG_SWEEP_UP:   sweep_up_q   <= pwdata[0];
				swtg_pkg::REG_TEMPO:      tempo_q      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (swtg_pkg::reg_idx_t'(paddr[4:2]))
			swtg_pkg::REG_MODE:       prdata = {30'd0, mode_q};
			swtg_pkg::REG_START_FREQ: prdata = {16'd0, start_freq_q};
			swtg_pkg::REG_LEVEL:      prdata = {24'd0, level_q};
			swtg_pkg::REG_DURATION:   prdata = {16'd0, duration_q};
			swtg_pkg::REG_STEP:       prdata = {16'd0, step_q};
			swtg_pkg::REG_SWEEP_UP:   prdata = {31'd0, sweep_up_q};
			swtg_pkg::REG_TEMPO:      prdata = {24'd0, tempo_q};
			default:                  prdata = '0;
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q    <= swtg_pkg::action_t'(s_tuser);
			naddr_q  <= s_tdata[5:0];
			nfreq_q  <= s_tdata[21:6];
			nlvl_q   <= s_tdata[29:22];
			nbeats_q <= s_tdata[45:30];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			swtg_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_nx = swtg_pkg::ST_EXEC;
			end
			swtg_pkg::ST_EXEC: begin
				state_nx = swtg_pkg::ST_DONE;
				unique case (act_q)
					swtg_pkg::ACT_TICK: begin
						if (tick_fire && active_mode_q == swtg_pkg::MODE_SONG)
							state_nx = swtg_pkg::ST_SONG_BEAT;
					end
					swtg_pkg::ACT_START: begin
						if (mode_q == swtg_pkg::MODE_SONG || mode_q == swtg_pkg::MODE_SWEEP)
							state_nx = swtg_pkg::ST_DIV;
					end
					swtg_pkg::ACT_PWM, swtg_pkg::ACT_NOTE: ;
				endcase
			end
			swtg_pkg::ST_SONG_BEAT: begin
				if (!beat_end)
					state_nx = swtg_pkg::ST_DONE;
				else if (idx_wrap)
					state_nx = swtg_pkg::ST_PLAY;
				else
					state_nx = swtg_pkg::ST_SONG_NEXT;
			end
			swtg_pkg::ST_SONG_NEXT: state_nx = swtg_pkg::ST_PLAY;
			swtg_pkg::ST_PLAY:      state_nx = swtg_pkg::ST_DONE;
			swtg_pkg::ST_DIV: begin
				if (div_cnt_q == 4'hF)
					state_nx = swtg_pkg::ST_DIV_END;
			end
			swtg_pkg::ST_DIV_END: begin
				state_nx = div_song_q ? swtg_pkg::ST_PLAY : swtg_pkg::ST_DONE;
			end
			swtg_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready)
					state_nx = swtg_pkg::ST_IDLE;
			end
			default: state_nx = swtg_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '{mem_we: 1'b0, rd_en: 1'b0, rd_sel: swtg_pkg::RD_CUR,
		         div_load: 1'b0, out_load: 1'b0};
		unique case (state_q)
			swtg_pkg::ST_EXEC: begin
				unique case (act_q)
					swtg_pkg::ACT_NOTE: ctrl.mem_we = addr_ok;
					swtg_pkg::ACT_TICK: begin
						if (tick_fire && active_mode_q == swtg_pkg::MODE_SONG) begin
							ctrl.rd_en  = 1'b1;
							ctrl.rd_sel = swtg_pkg::RD_CUR;
						end
					end
					swtg_pkg::ACT_START: begin
						if (mode_q == swtg_pkg::MODE_SONG) begin
							ctrl.rd_en    = 1'b1;
							ctrl.rd_sel   = swtg_pkg::RD_ZERO;
							ctrl.div_load = 1'b1;
						end else if (mode_q == swtg_pkg::MODE_SWEEP) begin
							ctrl.div_load = 1'b1;
						end
					end
					swtg_pkg::ACT_PWM: ;
				endcase
			end
			swtg_pkg::ST_SONG_BEAT: begin
				if (beat_end) begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = idx_wrap ? swtg_pkg::RD_ZERO : swtg_pkg::RD_NEXT;
				end
			end
			swtg_pkg::ST_SONG_NEXT: begin
				// a zero-frequency note ends the song: play from the top
				if (rd_q.freq == 16'd0) begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = swtg_pkg::RD_ZERO;
				end
			end
			swtg_pkg::ST_DONE: ctrl.out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_comb begin
		case (ctrl.rd_sel)
			swtg_pkg::RD_NEXT: rd_addr = idx_inc[IW-1:0];
			swtg_pkg::RD_ZERO: rd_addr = '0;
			default:           rd_addr = note_index_q;
		endcase
	end

	// note table
	always_ff @(posedge clk) begin
		if (ctrl.mem_we)
			mem[wr_addr] <= wr_data;
		if (ctrl.rd_en)
			rd_q <= mem[rd_addr];
	end

	// shared divider datapath
	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			rem_q <= '0;
			if (mode_q == swtg_pkg::MODE_SONG) begin
				quo_q <= swtg_pkg::BEAT_BASE_MS;
				den_q <= tempo16;
			end else begin
				quo_q <= duration_q;
				den_q <= stp;
			end
		end else if (state_q == swtg_pkg::ST_DIV) begin
			rem_q <= div_ge ? rem_diff[15:0] : rem_sh[15:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
	end

	// core state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= swtg_pkg::ST_IDLE;
			pwm_count_q    <= '0;
			half_period_q  <= '0;
			cur_level_q    <= '0;
			duty_q         <= '0;
			toggle_q       <= 1'b0;
			timer_run_q    <= 1'b0;
			ms_count_q     <= '0;
			timer_period_q <= '0;
			beat_count_q   <= '0;
			note_index_q   <= '0;
			sweep_index_q  <= '0;
			sweep_steps_q  <= '0;
			active_mode_q  <= swtg_pkg::MODE_OFF;
			div_song_q     <= 1'b0;
			div_cnt_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (ctrl.div_load)
				div_cnt_q <= '0;
			unique case (state_q)
				swtg_pkg::ST_EXEC: begin
					unique case (act_q)
						swtg_pkg::ACT_PWM: begin
							if (toggle_q) begin
								if (pwm_inc >= half_period_q) begin
									pwm_count_q <= '0;
									duty_q      <= (duty_q != 8'd0) ? 8'd0 : cur_level_q;
								end else begin
									pwm_count_q <= pwm_inc;
								end
							end
						end
						swtg_pkg::ACT_TICK: begin
							if (tick_fire) begin
								ms_count_q <= '0;
								unique case (active_mode_q)
									swtg_pkg::MODE_OFF: timer_run_q <= 1'b0;
									swtg_pkg::MODE_TONE: begin
										duty_q      <= '0;
										toggle_q    <= 1'b0;
										timer_run_q <= 1'b0;
									end
									swtg_pkg::MODE_SONG: ;
									swtg_pkg::MODE_SWEEP: begin
										if (sweep_index_q < sweep_steps_q) begin
											sweep_index_q <= sw_inc;
											half_period_q <= {1'b0, sw_freq[15:1]};
											cur_level_q   <= level_q;
											// last step of the sweep: go quiet
											if (sw_inc == sweep_steps_q) begin
												duty_q      <= '0;
												toggle_q    <= 1'b0;
												timer_run_q <= 1'b0;
											end
										end
									end
								endcase
							end else if (timer_run_q) begin
								ms_count_q <= ms_inc;
							end
						end
						swtg_pkg::ACT_START: begin
							active_mode_q <= mode_q;
							unique case (mode_q)
								swtg_pkg::MODE_OFF: begin
									duty_q      <= '0;
									toggle_q    <= 1'b0;
									timer_run_q <= 1'b0;
								end
								swtg_pkg::MODE_TONE: begin
									toggle_q       <= 1'b1;
									pwm_count_q    <= '0;
									half_period_q  <= {1'b0, start_freq_q[15:1]};
									cur_level_q    <= level_q;
									duty_q         <= level_q;
									timer_run_q    <= 1'b1;
									timer_period_q <= duration_q;
									ms_count_q     <= '0;
								end
								swtg_pkg::MODE_SONG: begin
									toggle_q     <= 1'b1;
									pwm_count_q  <= '0;
									timer_run_q  <= 1'b1;
									ms_count_q   <= '0;
									beat_count_q <= '0;
									note_index_q <= '0;
									div_song_q   <= 1'b1;
								end
								swtg_pkg::MODE_SWEEP: begin
									toggle_q       <= 1'b1;
									sweep_index_q  <= '0;
									half_period_q  <= {1'b0, start_freq_q[15:1]};
									cur_level_q    <= level_q;
									duty_q         <= level_q;
									timer_run_q    <= 1'b1;
									timer_period_q <= stp;
									ms_count_q     <= '0;
									div_song_q     <= 1'b0;
								end
							endcase
						end
						swtg_pkg::ACT_NOTE: ;
					endcase
				end
				swtg_pkg::ST_SONG_BEAT: begin
					if (beat_end) begin
						beat_count_q <= '0;
						if (idx_wrap)
							note_index_q <= '0;
					end else begin
						beat_count_q <= beat_inc;
					end
				end
				swtg_pkg::ST_SONG_NEXT: begin
					note_index_q <= (rd_q.freq == 16'd0) ? '0 : idx_inc[IW-1:0];
				end
				swtg_pkg::ST_PLAY: begin
					half_period_q <= {1'b0, rd_q.freq[15:1]};
					cur_level_q   <= rd_q.lvl;
					duty_q        <= rd_q.lvl;
				end
				swtg_pkg::ST_DIV: div_cnt_q <= div_cnt_q + 4'd1;
				swtg_pkg::ST_DIV_END: begin
					if (div_song_q)
						timer_period_q <= quo_q;
					else
						sweep_steps_q <= quo_q;
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctrl.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load)
			m_tdata_q <= {1'b0, idx_w[5:0], toggle_q, duty_q};
	end

endmodule
